>>> design/jcg_pkg.sv
// types, constants and helpers for the joint command guard
`timescale 1ns / 1ps
`default_nettype none

package jcg_pkg;

    // joint count and field widths
    localparam int NUM_JOINTS = 6;
    localparam int JIDX_W     = $clog2(NUM_JOINTS);
    localparam int JOINT_W    = 3;
    localparam int CMD_W      = 3;
    localparam int POS_W      = 24;
    localparam int VEL_W      = 24;
    localparam int GAIN_W     = 18;
    localparam int LVEL_W     = 23;
    localparam int FAULT_W    = 3;
    localparam int DIFF_W     = POS_W + 1;
    localparam int UW_W       = POS_W + 2;

    // configuration port
    localparam int TOL_W      = 20;
    localparam int GMAX_W     = 17;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TOL_W-1:0]  TOL_RST    = TOL_W'(52429);
    localparam logic              LIM_EN_RST = 1'b0;
    localparam logic [GMAX_W-1:0] KP_MAX_RST = GMAX_W'(51200);
    localparam logic [GMAX_W-1:0] KD_MAX_RST = GMAX_W'(20480);

    // 2*pi in 2^-20 rad, and the half-turn edges where the unwrap count steps
    localparam int TWO_PI_UNITS = 6588397;
    localparam int K1_EDGE      = (TWO_PI_UNITS + 1) / 2;
    localparam int K2_EDGE      = (3 * TWO_PI_UNITS + 1) / 2;
    localparam int K3_EDGE      = (5 * TWO_PI_UNITS + 1) / 2;

    localparam logic signed [DIFF_W-1:0] DIFF_K1  = DIFF_W'(K1_EDGE);
    localparam logic signed [DIFF_W-1:0] DIFF_K2  = DIFF_W'(K2_EDGE);
    localparam logic signed [DIFF_W-1:0] DIFF_K3  = DIFF_W'(K3_EDGE);
    localparam logic signed [DIFF_W-1:0] DIFF_NK1 = DIFF_W'(-K1_EDGE);
    localparam logic signed [DIFF_W-1:0] DIFF_NK2 = DIFF_W'(-K2_EDGE);
    localparam logic signed [DIFF_W-1:0] DIFF_NK3 = DIFF_W'(-K3_EDGE);

    localparam logic signed [UW_W-1:0] TURN_1 = UW_W'(TWO_PI_UNITS);
    localparam logic signed [UW_W-1:0] TURN_2 = UW_W'(2 * TWO_PI_UNITS);
    localparam logic signed [UW_W-1:0] TURN_3 = UW_W'(3 * TWO_PI_UNITS);

    // position memory has three lanes per joint: seed and two staging banks
    localparam int LANES = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_LIMITS = 3'd0,
        CMD_SEED         = 3'd1,
        CMD_CHECK        = 3'd2,
        CMD_ESTOP        = 3'd3,
        CMD_RELEASE      = 3'd4
    } t_cmd;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE    = 3'd0,
        FAULT_BLOCKED = 3'd1,
        FAULT_POS     = 3'd2,
        FAULT_VEL     = 3'd3,
        FAULT_KP      = 3'd4,
        FAULT_KD      = 3'd5
    } t_fault;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOL    = 2'd0,
        CFG_LIM_EN = 2'd1,
        CFG_KP_MAX = 2'd2,
        CFG_KD_MAX = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        LANE_SEED  = 2'd0,
        LANE_BANK0 = 2'd1,
        LANE_BANK1 = 2'd2
    } t_lane;

    typedef struct packed {
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic [LVEL_W-1:0] vel;
    } t_limits;

    typedef struct packed {
        logic              en;
        logic [JIDX_W-1:0] row;
        t_lane             lane;
        logic [POS_W-1:0]  data;
    } t_pos_wr;

    function automatic t_lane bank_lane(input logic bank);
        return bank ? LANE_BANK1 : LANE_BANK0;
    endfunction

endpackage

`default_nettype wire

>>> design/joint_command_guard.sv
// joint command guard: per-joint unwrap, limit, rate and gain checks with vector commit
//
// requests arrive on i_valid/o_ready, one joint element (or a table write, seed,
// estop or release) per request; every request returns exactly one result on
// o_valid/i_ready, in order
// configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_data), used
// only while no request is in flight
// pipeline: a request passes the stage 1 and stage 2 registers into the result
// register; o_valid is high from then until the result is taken
// throughput: one request per clock while results are taken; the limit is the
// position memory's single write port, used by the modify/write stage each cycle,
// with the read stage fed by forwarding from that stage and from the previous write
// limits table is written at acceptance; seeds, staged positions and commits are
// written in the second stage, so they stay in request order
// a commit flips per-joint bank pointers instead of copying six entries
// reset: limits and committed positions read as zero, estop latch set, all
// pipeline stages empty; no clearing pass is needed
// receiver stall: the result register holds, the two stages behind it fill, and
// o_ready drops only when all three are occupied
`timescale 1ns / 1ps
`default_nettype none

module joint_command_guard import jcg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // request channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [JOINT_W-1:0]       i_joint,
    input  logic signed [POS_W-1:0]  i_target_pos,
    input  logic signed [VEL_W-1:0]  i_target_vel,
    input  logic signed [GAIN_W-1:0] i_gain_kp,
    input  logic signed [GAIN_W-1:0] i_gain_kd,
    input  logic signed [POS_W-1:0]  i_limit_low,
    input  logic signed [POS_W-1:0]  i_limit_high,
    input  logic [LVEL_W-1:0]        i_limit_vel,
    input  logic                     i_last_joint,

    // configuration writes
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,

    // result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [JOINT_W-1:0]       o_joint_echo,
    output logic signed [POS_W-1:0]  o_clipped_pos,
    output logic [FAULT_W-1:0]       o_fault,
    output logic                     o_vector_done,
    output logic                     o_accepted,
    output logic                     o_blocked_now
);

    // ---------------------------------------------------------------
    // handshake and stage advance
    // ---------------------------------------------------------------
    logic in_fire;
    logic s1_adv;
    logic s2_fire;

    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;

    assign s2_fire = r_s2_valid && (!r_out_valid || i_ready);
    assign s1_adv  = r_s1_valid && (!r_s2_valid || s2_fire);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_fire = i_valid && o_ready;

    // incoming request decode
    t_cmd              in_cmd;
    logic              in_jok;
    logic [JIDX_W-1:0] in_idx;

    assign in_cmd = t_cmd'(i_cmd);
    assign in_jok = i_joint < JOINT_W'(NUM_JOINTS);
    // out-of-range joints read row zero; their result never uses it
    assign in_idx = in_jok ? i_joint[JIDX_W-1:0] : '0;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [TOL_W-1:0]  r_tol;
    logic              r_lim_en;
    logic [GMAX_W-1:0] r_kp_max;
    logic [GMAX_W-1:0] r_kd_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_RST;
            r_lim_en <= LIM_EN_RST;
            r_kp_max <= KP_MAX_RST;
            r_kd_max <= KD_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_TOL:    r_tol    <= i_cfg_data[TOL_W-1:0];
                CFG_LIM_EN: r_lim_en <= i_cfg_data[0];
                CFG_KP_MAX: r_kp_max <= i_cfg_data[GMAX_W-1:0];
                CFG_KD_MAX: r_kd_max <= i_cfg_data[GMAX_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // limits memory: written and read at acceptance, so request order
    // alone keeps reads coherent; valid bits give the zero reset
    // ---------------------------------------------------------------
    t_limits r_lim_mem [NUM_JOINTS];
    t_limits r_lim_rd;
    logic    r_lim_vld [NUM_JOINTS];

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (in_cmd == CMD_WRITE_LIMITS && in_jok) begin
                r_lim_mem[in_idx] <= {i_limit_low, i_limit_high, i_limit_vel};
            end
            r_lim_rd <= r_lim_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_lim_vld[j] <= 1'b0;
            end
        end else if (in_fire && in_cmd == CMD_WRITE_LIMITS && in_jok) begin
            r_lim_vld[in_idx] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // position memory: one row per joint, lanes for the seed and two
    // staging banks; per-joint pointers say which lane is committed
    // ---------------------------------------------------------------
    logic [POS_W-1:0] r_pos_mem [NUM_JOINTS][LANES];
    logic [POS_W-1:0] r_pos_rd  [LANES];
    t_pos_wr          s2_wr;
    t_pos_wr          r_fwd;

    always_ff @(posedge i_clk) begin
        if (s2_wr.en) begin
            r_pos_mem[s2_wr.row][s2_wr.lane] <= s2_wr.data;
        end
        if (in_fire) begin
            for (int l = 0; l < LANES; l++) begin
                r_pos_rd[l] <= r_pos_mem[in_idx][l];
            end
        end
    end

    // write that lands on the same edge as a read is missed by it: keep it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= '0;
        end else if (in_fire) begin
            r_fwd <= s2_wr;
        end
    end

    // committed lane, latest staging bank and seed-written flag per joint
    t_lane r_cp [NUM_JOINTS];
    logic  r_sw [NUM_JOINTS];
    logic  r_sv [NUM_JOINTS];
    t_lane n_cp [NUM_JOINTS];
    logic  n_sw [NUM_JOINTS];
    logic  n_sv [NUM_JOINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_cp[j] <= LANE_SEED;
                r_sw[j] <= 1'b0;
                r_sv[j] <= 1'b0;
            end
        end else begin
            r_cp <= n_cp;
            r_sw <= n_sw;
            r_sv <= n_sv;
        end
    end

    // ---------------------------------------------------------------
    // stage 1 registers: request fields, captured at acceptance
    // ---------------------------------------------------------------
    t_cmd                     r_s1_cmd;
    logic [JOINT_W-1:0]       r_s1_joint;
    logic                     r_s1_jok;
    logic [JIDX_W-1:0]        r_s1_idx;
    logic signed [POS_W-1:0]  r_s1_tpos;
    logic signed [VEL_W-1:0]  r_s1_tvel;
    logic signed [GAIN_W-1:0] r_s1_kp;
    logic signed [GAIN_W-1:0] r_s1_kd;
    logic                     r_s1_last;
    logic                     r_s1_lim_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_fire || (r_s1_valid && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd    <= in_cmd;
            r_s1_joint  <= i_joint;
            r_s1_jok    <= in_jok;
            r_s1_idx    <= in_idx;
            r_s1_tpos   <= i_target_pos;
            r_s1_tvel   <= i_target_vel;
            r_s1_kp     <= i_gain_kp;
            r_s1_kd     <= i_gain_kd;
            r_s1_last   <= i_last_joint;
            r_s1_lim_ok <= in_jok && r_lim_vld[in_idx];
        end
    end

    // ---------------------------------------------------------------
    // stage 1 logic: forwarded committed position, unwrap, bounds and
    // the rate and gain checks
    // ---------------------------------------------------------------
    logic [POS_W-1:0]         s1_row [LANES];
    t_lane                    s1_ptr;
    logic [POS_W-1:0]         s1_ref;
    logic signed [DIFF_W-1:0] s1_diff;
    logic signed [UW_W-1:0]   s1_tpos_w;
    logic signed [UW_W-1:0]   s1_unw;
    logic signed [UW_W-1:0]   s1_p;
    logic [POS_W-1:0]         s1_lo;
    logic [POS_W-1:0]         s1_hi;
    logic [LVEL_W-1:0]        s1_vlim;
    logic signed [UW_W-1:0]   s1_lo_m;
    logic signed [UW_W-1:0]   s1_hi_p;
    logic [VEL_W-1:0]         s1_vmag;
    logic                     s1_vel_bad;
    logic                     s1_kp_bad;
    logic                     s1_kd_bad;

    always_comb begin
        // row as it stands after every older write
        s1_row = r_pos_rd;
        if (r_fwd.en && r_fwd.row == r_s1_idx) begin
            s1_row[r_fwd.lane] = r_fwd.data;
        end
        if (s2_wr.en && s2_wr.row == r_s1_idx) begin
            s1_row[s2_wr.lane] = s2_wr.data;
        end

        // pointers include whatever the older request in stage 2 changes
        s1_ptr = n_cp[r_s1_idx];
        if (s1_ptr == LANE_SEED && !n_sv[r_s1_idx]) begin
            s1_ref = '0;
        end else begin
            s1_ref = s1_row[s1_ptr];
        end

        s1_diff   = {r_s1_tpos[POS_W-1], r_s1_tpos} - {s1_ref[POS_W-1], s1_ref};
        s1_tpos_w = {{2{r_s1_tpos[POS_W-1]}}, r_s1_tpos};

        // turn count is at most three either way for 24-bit angles
        priority if (s1_diff >= DIFF_K3) begin
            s1_unw = s1_tpos_w - TURN_3;
        end else if (s1_diff >= DIFF_K2) begin
            s1_unw = s1_tpos_w - TURN_2;
        end else if (s1_diff >= DIFF_K1) begin
            s1_unw = s1_tpos_w - TURN_1;
        end else if (s1_diff <= DIFF_NK3) begin
            s1_unw = s1_tpos_w + TURN_3;
        end else if (s1_diff <= DIFF_NK2) begin
            s1_unw = s1_tpos_w + TURN_2;
        end else if (s1_diff <= DIFF_NK1) begin
            s1_unw = s1_tpos_w + TURN_1;
        end else begin
            s1_unw = s1_tpos_w;
        end

        // seeds, and checks with limits disabled, carry the raw target through
        if (r_s1_cmd == CMD_CHECK && r_lim_en) begin
            s1_p = s1_unw;
        end else begin
            s1_p = s1_tpos_w;
        end

        // never-written limit rows read as zero
        if (r_s1_lim_ok) begin
            s1_lo   = r_lim_rd.lo;
            s1_hi   = r_lim_rd.hi;
            s1_vlim = r_lim_rd.vel;
        end else begin
            s1_lo   = '0;
            s1_hi   = '0;
            s1_vlim = '0;
        end
        s1_lo_m = {{2{s1_lo[POS_W-1]}}, s1_lo} - {{(UW_W-TOL_W){1'b0}}, r_tol};
        s1_hi_p = {{2{s1_hi[POS_W-1]}}, s1_hi} + {{(UW_W-TOL_W){1'b0}}, r_tol};

        s1_vmag    = r_s1_tvel[VEL_W-1] ? (~r_s1_tvel + 1'b1) : r_s1_tvel;
        s1_vel_bad = s1_vmag > {1'b0, s1_vlim};
        s1_kp_bad  = r_s1_kp[GAIN_W-1] || (r_s1_kp[GAIN_W-2:0] > r_kp_max);
        s1_kd_bad  = r_s1_kd[GAIN_W-1] || (r_s1_kd[GAIN_W-2:0] > r_kd_max);
    end

    // ---------------------------------------------------------------
    // stage 2 registers
    // ---------------------------------------------------------------
    t_cmd                    r_s2_cmd;
    logic [JOINT_W-1:0]      r_s2_joint;
    logic                    r_s2_jok;
    logic [JIDX_W-1:0]       r_s2_idx;
    logic signed [UW_W-1:0]  r_s2_p;
    logic signed [POS_W-1:0] r_s2_lo;
    logic signed [POS_W-1:0] r_s2_hi;
    logic signed [UW_W-1:0]  r_s2_lo_m;
    logic signed [UW_W-1:0]  r_s2_hi_p;
    logic                    r_s2_vel_bad;
    logic                    r_s2_kp_bad;
    logic                    r_s2_kd_bad;
    logic                    r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= s1_adv || (r_s2_valid && !s2_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_cmd     <= r_s1_cmd;
            r_s2_joint   <= r_s1_joint;
            r_s2_jok     <= r_s1_jok;
            r_s2_idx     <= r_s1_idx;
            r_s2_p       <= s1_p;
            r_s2_lo      <= s1_lo;
            r_s2_hi      <= s1_hi;
            r_s2_lo_m    <= s1_lo_m;
            r_s2_hi_p    <= s1_hi_p;
            r_s2_vel_bad <= s1_vel_bad;
            r_s2_kp_bad  <= s1_kp_bad;
            r_s2_kd_bad  <= s1_kd_bad;
            r_s2_last    <= r_s1_last;
        end
    end

    // ---------------------------------------------------------------
    // stage 2 logic: clamp, fault priority, latches, memory writes and
    // the commit
    // ---------------------------------------------------------------
    logic                    r_blocked;
    logic                    r_rej;
    logic                    n_blocked;
    logic                    n_rej;

    logic signed [UW_W-1:0]  s2_lo_w;
    logic signed [UW_W-1:0]  s2_hi_w;
    logic signed [UW_W-1:0]  s2_pos;
    logic                    s2_pos_bad;
    t_fault                  s2_fault;
    logic                    s2_rej;
    logic                    s2_stg_bank;
    logic signed [POS_W-1:0] s2_out_pos;
    t_fault                  s2_out_fault;
    logic                    s2_out_done;
    logic                    s2_out_acc;

    always_comb begin
        s2_lo_w    = {{2{r_s2_lo[POS_W-1]}}, r_s2_lo};
        s2_hi_w    = {{2{r_s2_hi[POS_W-1]}}, r_s2_hi};
        s2_pos     = r_s2_p;
        s2_pos_bad = 1'b0;
        // with lower above upper, a low value still clamps low first
        if (r_lim_en) begin
            priority if (r_s2_p < r_s2_lo_m || r_s2_p > r_s2_hi_p) begin
                s2_pos_bad = 1'b1;
            end else if (r_s2_p < s2_lo_w) begin
                s2_pos = s2_lo_w;
            end else if (r_s2_p > s2_hi_w) begin
                s2_pos = s2_hi_w;
            end else begin
                s2_pos = r_s2_p;
            end
        end

        priority if (r_blocked) begin
            s2_fault = FAULT_BLOCKED;
        end else if (!r_s2_jok || s2_pos_bad) begin
            s2_fault = FAULT_POS;
        end else if (r_s2_vel_bad) begin
            s2_fault = FAULT_VEL;
        end else if (r_s2_kp_bad) begin
            s2_fault = FAULT_KP;
        end else if (r_s2_kd_bad) begin
            s2_fault = FAULT_KD;
        end else begin
            s2_fault = FAULT_NONE;
        end

        s2_rej = r_rej || (s2_fault != FAULT_NONE);

        // stage into the bank that is not committed
        if (r_cp[r_s2_idx] == bank_lane(r_sw[r_s2_idx])) begin
            s2_stg_bank = !r_sw[r_s2_idx];
        end else begin
            s2_stg_bank = r_sw[r_s2_idx];
        end

        n_blocked    = r_blocked;
        n_rej        = r_rej;
        n_cp         = r_cp;
        n_sw         = r_sw;
        n_sv         = r_sv;
        s2_wr        = '0;
        s2_out_pos   = '0;
        s2_out_fault = FAULT_NONE;
        s2_out_done  = 1'b0;
        s2_out_acc   = 1'b0;

        if (s2_fire) begin
            unique case (r_s2_cmd)
                CMD_SEED: begin
                    if (r_s2_jok) begin
                        s2_wr.en           = 1'b1;
                        s2_wr.row          = r_s2_idx;
                        s2_wr.lane         = LANE_SEED;
                        s2_wr.data         = r_s2_p[POS_W-1:0];
                        n_sv[r_s2_idx]     = 1'b1;
                        n_cp[r_s2_idx]     = LANE_SEED;
                    end
                end
                CMD_ESTOP: begin
                    n_blocked = 1'b1;
                end
                CMD_RELEASE: begin
                    n_blocked = 1'b0;
                end
                CMD_CHECK: begin
                    s2_out_fault = s2_fault;
                    if (s2_fault != FAULT_BLOCKED && s2_fault != FAULT_POS) begin
                        s2_out_pos = s2_pos[POS_W-1:0];
                    end
                    if (s2_fault == FAULT_NONE) begin
                        s2_wr.en       = 1'b1;
                        s2_wr.row      = r_s2_idx;
                        s2_wr.lane     = bank_lane(s2_stg_bank);
                        s2_wr.data     = s2_pos[POS_W-1:0];
                        n_sw[r_s2_idx] = s2_stg_bank;
                    end
                    n_rej = s2_rej;
                    if (r_s2_last) begin
                        s2_out_done = 1'b1;
                        n_rej       = 1'b0;
                        if (!s2_rej) begin
                            // commit: every joint now points at its latest stage
                            s2_out_acc = 1'b1;
                            for (int j = 0; j < NUM_JOINTS; j++) begin
                                n_cp[j] = bank_lane(n_sw[j]);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked <= 1'b1;
            r_rej     <= 1'b0;
        end else begin
            r_blocked <= n_blocked;
            r_rej     <= n_rej;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic [JOINT_W-1:0]      r_out_joint;
    logic signed [POS_W-1:0] r_out_pos;
    t_fault                  r_out_fault;
    logic                    r_out_done;
    logic                    r_out_acc;
    logic                    r_out_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= s2_fire || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out_joint   <= r_s2_joint;
            r_out_pos     <= s2_out_pos;
            r_out_fault   <= s2_out_fault;
            r_out_done    <= s2_out_done;
            r_out_acc     <= s2_out_acc;
            r_out_blocked <= n_blocked;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_joint_echo  = r_out_joint;
    assign o_clipped_pos = r_out_pos;
    assign o_fault       = r_out_fault;
    assign o_vector_done = r_out_done;
    assign o_accepted    = r_out_acc;
    assign o_blocked_now = r_out_blocked;

endmodule

`default_nettype wire

>>> tb/joint_command_guard_tb.sv
// self-checking testbench for the joint command guard
`timescale 1ns / 1ps

module joint_command_guard_tb;
    import jcg_pkg::*;

    // unused command code, the block ignores it
    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

    // signed field extremes and the run limit
    localparam longint POS_TOP    = 2**(POS_W-1) - 1;
    localparam longint POS_BOTTOM = -(2**(POS_W-1));
    localparam longint VEL_TOP    = 2**(VEL_W-1) - 1;
    localparam longint GAIN_TOP   = 2**(GAIN_W-1) - 1;
    localparam longint LVEL_TOP   = 2**LVEL_W - 1;
    localparam longint TURN       = TWO_PI_UNITS;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     PHASE_REQUESTS = 150;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [JOINT_W-1:0]       joint;
        logic signed [POS_W-1:0]  tpos;
        logic signed [VEL_W-1:0]  tvel;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] kd;
        logic signed [POS_W-1:0]  llo;
        logic signed [POS_W-1:0]  lhi;
        logic [LVEL_W-1:0]        lvel;
        logic                     last;
    } t_joint_request;

    typedef struct {
        logic [JOINT_W-1:0]      joint;
        logic signed [POS_W-1:0] clipped;
        t_fault                  fault;
        logic                    done;
        logic                    acc;
        logic                    blocked;
    } t_guard_result;

    // clock, reset and all block inputs start at known values
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic [CMD_W-1:0]         i_cmd = '0;
    logic [JOINT_W-1:0]       i_joint = '0;
    logic signed [POS_W-1:0]  i_target_pos = '0;
    logic signed [VEL_W-1:0]  i_target_vel = '0;
    logic signed [GAIN_W-1:0] i_gain_kp = '0;
    logic signed [GAIN_W-1:0] i_gain_kd = '0;
    logic signed [POS_W-1:0]  i_limit_low = '0;
    logic signed [POS_W-1:0]  i_limit_high = '0;
    logic [LVEL_W-1:0]        i_limit_vel = '0;
    logic                     i_last_joint = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_ready = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic [JOINT_W-1:0]       o_joint_echo;
    logic signed [POS_W-1:0]  o_clipped_pos;
    logic [FAULT_W-1:0]       o_fault;
    logic                     o_vector_done;
    logic                     o_accepted;
    logic                     o_blocked_now;

    joint_command_guard uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_joint       (i_joint),
        .i_target_pos  (i_target_pos),
        .i_target_vel  (i_target_vel),
        .i_gain_kp     (i_gain_kp),
        .i_gain_kd     (i_gain_kd),
        .i_limit_low   (i_limit_low),
        .i_limit_high  (i_limit_high),
        .i_limit_vel   (i_limit_vel),
        .i_last_joint  (i_last_joint),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_joint_echo  (o_joint_echo),
        .o_clipped_pos (o_clipped_pos),
        .o_fault       (o_fault),
        .o_vector_done (o_vector_done),
        .o_accepted    (o_accepted),
        .o_blocked_now (o_blocked_now)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // requests waiting to be offered, and results owed by the block in order
    t_joint_request pending_commands[$];
    t_guard_result  results_due[$];
    int             errors = 0;
    int             cycle_count = 0;

    // shadow of the guard state, advanced as each request is accepted
    logic signed [POS_W-1:0] low_limit  [NUM_JOINTS];
    logic signed [POS_W-1:0] high_limit [NUM_JOINTS];
    logic [LVEL_W-1:0]       speed_limit[NUM_JOINTS];
    logic signed [POS_W-1:0] committed  [NUM_JOINTS];
    logic signed [POS_W-1:0] staged     [NUM_JOINTS];
    logic                    vector_spoilt = 1'b0;
    logic                    estop_latched = 1'b1;

    // shadow of the configuration registers, reset values first
    logic [TOL_W-1:0]  tolerance_reg = TOL_RST;
    logic              limits_on_reg = LIM_EN_RST;
    logic [GMAX_W-1:0] kp_max_reg    = KP_MAX_RST;
    logic [GMAX_W-1:0] kd_max_reg    = KD_MAX_RST;

    // stimulus-side view of the limit tables and estop latch, kept in queue order
    longint gen_low [NUM_JOINTS];
    longint gen_high[NUM_JOINTS];
    longint gen_vlim[NUM_JOINTS];
    bit     gen_blocked = 1'b1;
    int     counted = 0;

    // handshake bookkeeping shared by driver, monitor and the stimulus thread
    t_joint_request in_flight;
    bit             offering = 1'b0;
    int             send_gap = 0;
    int             send_calm = 0;
    int             ready_gap = 0;
    int             ready_calm = 0;
    int             hold_left = 0;
    bit             long_hold_armed = 1'b0;

    // gap length: mostly none, some short, a few long, with calm stretches of none
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 4)
            calm = $urandom_range(40, 200);
        if (r < 600)
            return 0;
        if (r < 900)
            return $urandom_range(1, 3);
        if (r < 985)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // works out the result of one accepted request and advances the shadow state
    function automatic void guard_verdict(input t_joint_request r);
        t_guard_result res;
        int            j;
        bit            joint_ok;
        longint        p, lo, hi, slack, diff, mag, turns, speed;
        j = r.joint;
        joint_ok = (j < NUM_JOINTS);
        res.joint   = r.joint;
        res.clipped = '0;
        res.fault   = FAULT_NONE;
        res.done    = 1'b0;
        res.acc     = 1'b0;
        case (r.cmd)
            CMD_WRITE_LIMITS: begin
                if (joint_ok) begin
                    low_limit[j]   = r.llo;
                    high_limit[j]  = r.lhi;
                    speed_limit[j] = r.lvel;
                end
            end
            CMD_SEED: begin
                if (joint_ok)
                    committed[j] = r.tpos;
            end
            CMD_ESTOP:   estop_latched = 1'b1;
            CMD_RELEASE: estop_latched = 1'b0;
            CMD_CHECK: begin
                if (estop_latched) begin
                    res.fault = FAULT_BLOCKED;
                end else if (!joint_ok) begin
                    res.fault = FAULT_POS;
                end else begin
                    p = r.tpos;
                    if (limits_on_reg) begin
                        lo    = low_limit[j];
                        hi    = high_limit[j];
                        slack = tolerance_reg;
                        // nearest turn to the committed angle, halves rounded away from zero
                        diff  = p - longint'(committed[j]);
                        mag   = (diff < 0) ? -diff : diff;
                        turns = (2 * mag + TURN) / (2 * TURN);
                        if (diff < 0)
                            turns = -turns;
                        p = p - turns * TURN;
                        if (p < lo - slack || p > hi + slack)
                            res.fault = FAULT_POS;
                        else if (p < lo)
                            p = lo;
                        else if (p > hi)
                            p = hi;
                    end
                    if (res.fault == FAULT_NONE) begin
                        speed = r.tvel;
                        if (speed < 0)
                            speed = -speed;
                        res.clipped = p[POS_W-1:0];
                        if (speed > longint'(speed_limit[j]))
                            res.fault = FAULT_VEL;
                        else if (r.kp < 0 || longint'(r.kp) > longint'(kp_max_reg))
                            res.fault = FAULT_KP;
                        else if (r.kd < 0 || longint'(r.kd) > longint'(kd_max_reg))
                            res.fault = FAULT_KD;
                    end
                    if (res.fault == FAULT_NONE)
                        staged[j] = p[POS_W-1:0];
                end
                if (res.fault != FAULT_NONE)
                    vector_spoilt = 1'b1;
                // last element closes the vector, committing every staged joint if clean
                if (r.last) begin
                    res.done = 1'b1;
                    if (!vector_spoilt) begin
                        res.acc = 1'b1;
                        for (int k = 0; k < NUM_JOINTS; k++)
                            committed[k] = staged[k];
                    end
                    vector_spoilt = 1'b0;
                end
            end
            default: ;
        endcase
        res.blocked = estop_latched;
        results_due.push_back(res);
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // request driver: holds each request until taken, then idles a random gap
    always @(posedge i_clk) begin : command_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                guard_verdict(in_flight);
                offering = 1'b0;
                send_gap = idle_len(send_calm);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_commands.size() > 0) begin
                    in_flight = pending_commands.pop_front();
                    i_cmd        <= in_flight.cmd;
                    i_joint      <= in_flight.joint;
                    i_target_pos <= in_flight.tpos;
                    i_target_vel <= in_flight.tvel;
                    i_gain_kp    <= in_flight.kp;
                    i_gain_kd    <= in_flight.kd;
                    i_limit_low  <= in_flight.llo;
                    i_limit_high <= in_flight.lhi;
                    i_limit_vel  <= in_flight.lvel;
                    i_last_joint <= in_flight.last;
                    i_valid      <= 1'b1;
                    offering = 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks every taken result, and stalls the block at random
    always @(posedge i_clk) begin : result_monitor
        t_guard_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (results_due.size() == 0) begin
                    $error("result for joint %0d arrived with nothing owed", o_joint_echo);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("joint_echo", want.joint, o_joint_echo);
                    compare_field("clipped_pos", want.clipped, o_clipped_pos);
                    compare_field("fault", want.fault, o_fault);
                    compare_field("vector_done", want.done, o_vector_done);
                    compare_field("accepted", want.acc, o_accepted);
                    compare_field("blocked_now", want.blocked, o_blocked_now);
                end
            end
            // one long hold-off lets the pipeline fill and push back on requests
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (long_hold_armed) begin
                long_hold_armed = 1'b0;
                hold_left = 300;
                i_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                ready_gap = idle_len(ready_calm);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // queue a request and track what it does to the limits and the estop latch
    task automatic send(input t_joint_request r);
        int j;
        j = r.joint;
        pending_commands.push_back(r);
        case (r.cmd)
            CMD_WRITE_LIMITS: begin
                if (j < NUM_JOINTS) begin
                    gen_low[j]  = r.llo;
                    gen_high[j] = r.lhi;
                    gen_vlim[j] = r.lvel;
                    counted++;
                end
            end
            CMD_SEED: begin
                if (j < NUM_JOINTS)
                    counted++;
            end
            CMD_CHECK: counted++;
            CMD_ESTOP: begin
                gen_blocked = 1'b1;
                counted++;
            end
            CMD_RELEASE: begin
                gen_blocked = 1'b0;
                counted++;
            end
            default: ;
        endcase
    endtask

    // every field random, then the command and joint imposed
    function automatic t_joint_request make_request(input logic [CMD_W-1:0] cmd,
                                                    input int j);
        t_joint_request r;
        r.cmd   = cmd;
        r.joint = JOINT_W'(j);
        r.tpos  = POS_W'($urandom);
        r.tvel  = VEL_W'($urandom);
        r.kp    = GAIN_W'($urandom);
        r.kd    = GAIN_W'($urandom);
        r.llo   = POS_W'($urandom);
        r.lhi   = POS_W'($urandom);
        r.lvel  = LVEL_W'($urandom);
        r.last  = 1'($urandom);
        return r;
    endfunction

    function automatic t_joint_request make_check(input int j, input longint pos,
                                                  input longint vel, input longint kp,
                                                  input longint kd, input bit last);
        t_joint_request r;
        r = make_request(CMD_CHECK, j);
        r.tpos = POS_W'(pos);
        r.tvel = VEL_W'(vel);
        r.kp   = GAIN_W'(kp);
        r.kd   = GAIN_W'(kd);
        r.last = last;
        return r;
    endfunction

    function automatic t_joint_request make_limits(input int j, input longint lo,
                                                   input longint hi, input longint vl);
        t_joint_request r;
        r = make_request(CMD_WRITE_LIMITS, j);
        r.llo  = POS_W'(lo);
        r.lhi  = POS_W'(hi);
        r.lvel = LVEL_W'(vl);
        return r;
    endfunction

    // limits around a random centre, sometimes reversed, sometimes the full range
    function automatic t_joint_request random_limits(input int j);
        longint c, w, lo, hi, vl;
        int     r;
        c  = longint'($urandom_range(0, 6000000)) - 3000000;
        w  = $urandom_range(0, 2500000);
        lo = c - w;
        hi = c + w;
        r  = $urandom_range(0, 99);
        if (r < 10) begin
            lo = c + w;
            hi = c - w;
        end else if (r < 15) begin
            lo = POS_BOTTOM;
            hi = POS_TOP;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
            vl = $urandom_range(0, 2000000);
        else if (r < 90)
            vl = $urandom_range(0, 32'(LVEL_TOP));
        else
            vl = $urandom_range(0, 1) ? LVEL_TOP : 0;
        return make_limits(j, lo, hi, vl);
    endfunction

    // angle aimed inside, at the edges, or just past the tolerance band,
    // sometimes a whole turn away so the unwrap has to bring it back
    function automatic longint pick_target(input int j);
        longint lo, hi, slack, p;
        int     r;
        lo    = (gen_low[j] < gen_high[j]) ? gen_low[j] : gen_high[j];
        hi    = (gen_low[j] < gen_high[j]) ? gen_high[j] : gen_low[j];
        slack = tolerance_reg;
        r     = $urandom_range(0, 99);
        if (r < 45) begin
            p = lo + longint'($urandom_range(0, 32'(hi - lo)));
        end else if (r < 70) begin
            p = ($urandom_range(0, 1) ? lo : hi)
                + longint'($urandom_range(0, 32'(2 * slack + 128))) - (slack + 64);
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       p = lo - slack;
                1:       p = lo - slack - 1;
                2:       p = hi + slack;
                default: p = hi + slack + 1;
            endcase
        end else begin
            p = longint'($urandom_range(0, 32'(POS_TOP - POS_BOTTOM))) + POS_BOTTOM;
        end
        if (r < 85 && $urandom_range(0, 9) < 4)
            p = p + ($urandom_range(0, 1) ? TURN : -TURN);
        if (p > POS_TOP)
            p = POS_TOP;
        if (p < POS_BOTTOM)
            p = POS_BOTTOM;
        return p;
    endfunction

    function automatic longint pick_velocity(input int j);
        longint vl, mag, v;
        int     r;
        vl = gen_vlim[j];
        r  = $urandom_range(0, 99);
        if (r < 85)
            mag = $urandom_range(0, 32'(vl));
        else if (r < 92)
            mag = vl;
        else
            mag = vl + 1 + $urandom_range(0, 1000);
        if (mag > VEL_TOP + 1)
            mag = VEL_TOP + 1;
        v = $urandom_range(0, 1) ? -mag : mag;
        if (v > VEL_TOP)
            v = -v;
        return v;
    endfunction

    function automatic longint pick_gain(input longint gmax);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return gmax;
        if (r < 14)
            return 0;
        if (r < 88)
            return $urandom_range(0, 32'(gmax));
        if (r < 94 || gmax >= GAIN_TOP)
            return -longint'($urandom_range(1, 32'(GAIN_TOP + 1)));
        return gmax + longint'($urandom_range(1, 32'(GAIN_TOP - gmax)));
    endfunction

    // register write, only ever issued with nothing in flight
    task automatic set_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TOL:    tolerance_reg = data[TOL_W-1:0];
            CFG_LIM_EN: limits_on_reg = data[0];
            CFG_KP_MAX: kp_max_reg    = data[GMAX_W-1:0];
            CFG_KD_MAX: kd_max_reg    = data[GMAX_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender pause: nothing queued, nothing offered, nothing owed, pipeline drained
    task automatic wait_for_idle();
        while (pending_commands.size() > 0 || offering || results_due.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // a vector of check elements, sometimes with a release, limits rewrite or seed ahead of it
    task automatic send_vector();
        t_joint_request r;
        int             len, j;
        bit             in_order;
        if (gen_blocked && $urandom_range(0, 9) != 0)
            send(make_request(CMD_RELEASE, $urandom_range(0, 7)));
        if ($urandom_range(0, 3) == 0)
            send(random_limits($urandom_range(0, NUM_JOINTS - 1)));
        if ($urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, NUM_JOINTS - 1);
            r = make_request(CMD_SEED, j);
            if ($urandom_range(0, 9) < 6)
                r.tpos = POS_W'(pick_target(j));
            send(r);
        end
        in_order = ($urandom_range(0, 1) == 1);
        len = in_order ? NUM_JOINTS : $urandom_range(1, NUM_JOINTS);
        for (int i = 0; i < len; i++) begin
            if (in_order)
                j = i;
            else if ($urandom_range(0, 19) == 0)
                j = $urandom_range(NUM_JOINTS, 7);
            else
                j = $urandom_range(0, NUM_JOINTS - 1);
            // a stray vector now and then runs on into the next one
            send(make_check(j, (j < NUM_JOINTS) ? pick_target(j) : 0,
                            (j < NUM_JOINTS) ? pick_velocity(j) : 0,
                            pick_gain(kp_max_reg), pick_gain(kd_max_reg),
                            (i == len - 1) && ($urandom_range(0, 19) != 0)));
        end
    endtask

    initial begin : stimulus
        t_joint_request r;
        int             target, pick;
        logic [TOL_W-1:0]  tol;
        logic              en;
        logic [GMAX_W-1:0] kpm, kdm;
        for (int k = 0; k < NUM_JOINTS; k++) begin
            low_limit[k]   = '0;
            high_limit[k]  = '0;
            speed_limit[k] = '0;
            committed[k]   = '0;
            staged[k]      = '0;
            gen_low[k]     = 0;
            gen_high[k]    = 0;
            gen_vlim[k]    = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a lone element straight out of reset meets the estop latch
        send(make_check(0, 1000, 0, 0, 0, 1'b1));
        send(make_request(CMD_ESTOP, 0));
        send(make_request(CMD_RELEASE, 3));
        for (int k = 0; k < NUM_JOINTS - 1; k++)
            send(make_limits(k, -2000000, 2000000, 1000000));
        send(make_limits(NUM_JOINTS - 1, POS_BOTTOM, POS_TOP, LVEL_TOP));
        // table write and seed for joints that do not exist are dropped
        send(make_limits(7, 5, 6, 7));
        r = make_request(CMD_SEED, NUM_JOINTS);
        r.tpos = POS_W'(1234);
        send(r);
        // clean vector: stages every joint, then commits at the last one
        send(make_check(0, -2000000, 1000000, 51200, 20480, 1'b0));
        send(make_check(1, 2000000, -1000000, 0, 0, 1'b0));
        send(make_check(2, 0, 0, 1, 1, 1'b0));
        send(make_check(3, 12345, 999999, 51199, 20479, 1'b0));
        send(make_check(4, -1, -1, 25600, 10240, 1'b0));
        send(make_check(NUM_JOINTS - 1, POS_BOTTOM, VEL_TOP, 51200, 20480, 1'b1));
        send(make_request(CMD_SPARE, 2));
        // one element each for the position, rate, kp and kd faults, the vector ends rejected
        send(make_check(NUM_JOINTS, 0, 0, 0, 0, 1'b0));
        send(make_check(1, 0, -VEL_TOP - 1, 0, 0, 1'b0));
        send(make_check(2, 0, 0, -1, 0, 1'b0));
        send(make_check(3, 0, 0, 0, 20481, 1'b1));
        r = make_request(CMD_SEED, 0);
        r.tpos = POS_W'(100);
        send(r);

        // random phases, each under its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            wait_for_idle();
            tol = TOL_W'($urandom);
            en  = 1'($urandom);
            kpm = GMAX_W'($urandom);
            kdm = GMAX_W'($urandom);
            case (phase)
                0: begin
                    tol = TOL_RST;
                    en  = 1'b1;
                    kpm = KP_MAX_RST;
                    kdm = KD_MAX_RST;
                end
                1: begin
                    tol = '0;
                    en  = 1'b1;
                    kpm = '0;
                    kdm = '0;
                end
                2: begin
                    tol = '1;
                    en  = 1'b1;
                    kpm = '1;
                    kdm = '1;
                end
                3: en = 1'b0;
                4: en = 1'b1;
                default: ;
            endcase
            // upper data bits beyond the enable and gain registers' widths are junk
            set_register(CFG_TOL, tol);
            set_register(CFG_LIM_EN, {19'($urandom), en});
            set_register(CFG_KP_MAX, {3'($urandom), kpm});
            set_register(CFG_KD_MAX, {3'($urandom), kdm});
            target = counted + PHASE_REQUESTS;
            while (counted < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_vector();
                end else if (pick < 80) begin
                    send(make_request(CMD_ESTOP, $urandom_range(0, 7)));
                    repeat ($urandom_range(0, 2))
                        send(make_check($urandom_range(0, NUM_JOINTS - 1), 0, 0, 0, 0,
                                        1'($urandom)));
                    if ($urandom_range(0, 9) < 7)
                        send(make_request(CMD_RELEASE, $urandom_range(0, 7)));
                end else begin
                    send(make_request(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 7)));
                end
            end
            if (phase == 0)
                long_hold_armed = 1'b1;
        end

        wait_for_idle();
        repeat (8) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d results never arrived", results_due.size());
            errors++;
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
